>>> rtl/arfp_pkg.sv
// Package for the actuator reply frame parser: frame constants, status codes
// and the record types passed between the front, the back and the queues.
// No dependencies.
package arfp_pkg;

   localparam logic [7:0] HDR0          = 8'hAA;
   localparam logic [7:0] HDR1          = 8'h55;
   localparam logic [8:0] LEN_EXTRA     = 9'd4;
   localparam logic [8:0] FORCE_MIN_LEN = 9'd15;
   localparam logic [8:0] SHORT_MIN_LEN = 9'd11;

   localparam logic [8:0] OFS_HDR0  = 9'd0;
   localparam logic [8:0] OFS_HDR1  = 9'd1;
   localparam logic [8:0] OFS_LEN   = 9'd2;
   localparam logic [8:0] OFS_ID    = 9'd3;
   localparam logic [8:0] OFS_POS_L = 9'd9;
   localparam logic [8:0] OFS_POS_H = 9'd10;
   localparam logic [8:0] OFS_FRC_L = 9'd13;
   localparam logic [8:0] OFS_FRC_H = 9'd14;

   localparam logic signed [15:0] POS_RESET = 16'sd1000;

   localparam int SLOT_IDX_W = 3;
   localparam int ID_TABLE_W = 64;
   localparam int ID_COUNT_W = 4;

   // Configuration register indexes.
   localparam logic CSR_ID_COUNT = 1'b0;
   localparam logic CSR_ID_TABLE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CSUM    = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_SHORT   = 2'd3
   } status_type;

   // One completed frame as the front hands it to the back.
   typedef struct packed {
      logic               sum_ok;
      logic [7:0]         reply_id;
      logic               is_short;
      logic               has_force;
      logic signed [15:0] position;
      logic signed [15:0] force_val;
   } frame_rec_type;

   typedef struct packed {
      status_type                status;
      logic [SLOT_IDX_W-1:0]     slot_index;
      logic signed [15:0]        position;
      logic signed [15:0]        force_res;
   } result_type;

endpackage

>>> rtl/arfp_fifo.sv
// Small synchronous queue with registered storage, used between the front and
// the back and as the result queue. No dependencies.
module arfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/arfp_front.sv
// Front of the parser: tracks the byte offset, checks the header, keeps the
// running checksum and captures id, position and force. Uses arfp_pkg.
module arfp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   start_of_burst,
   output logic                   rec_push,
   output arfp_pkg::frame_rec_type rec
);
   import arfp_pkg::*;

   logic [8:0]  offset_ff, offset_in;
   logic        hunting_ff, hunting_in;
   logic [8:0]  length_ff, length_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] frc_ff, frc_in;
   logic [8:0]  offset_cur;
   logic        active;

   assign offset_cur = start_of_burst ? '0 : offset_ff;
   assign active     = start_of_burst || !hunting_ff;

   always_comb begin
      offset_in  = offset_ff;
      hunting_in = hunting_ff;
      length_in  = length_ff;
      id_in      = id_ff;
      sum_in     = sum_ff;
      pos_in     = pos_ff;
      frc_in     = frc_ff;
      rec_push   = 1'b0;
      if (accept && active) begin
         hunting_in = 1'b0;
         offset_in  = offset_cur + 1'b1;
         priority if (offset_cur == OFS_HDR0) begin
            if (rx_byte != HDR0) hunting_in = 1'b1;
         end else if (offset_cur == OFS_HDR1) begin
            if (rx_byte != HDR1) hunting_in = 1'b1;
         end else if (offset_cur == OFS_LEN) begin
            length_in = {1'b0, rx_byte} + LEN_EXTRA;
            sum_in    = rx_byte;
         end else if (offset_cur < length_ff) begin
            sum_in = sum_ff + rx_byte;
            if (offset_cur == OFS_ID)    id_in         = rx_byte;
            if (offset_cur == OFS_POS_L) pos_in[7:0]   = rx_byte;
            if (offset_cur == OFS_POS_H) pos_in[15:8]  = rx_byte;
            if (offset_cur == OFS_FRC_L) frc_in[7:0]   = rx_byte;
            if (offset_cur == OFS_FRC_H) frc_in[15:8]  = rx_byte;
         end else begin
            // Checksum byte closes the frame.
            hunting_in = 1'b1;
            rec_push   = 1'b1;
         end
      end
   end

   always_comb begin
      rec.sum_ok    = (rx_byte == sum_ff);
      rec.reply_id  = id_ff;
      rec.is_short  = (length_ff < SHORT_MIN_LEN);
      rec.has_force = (length_ff >= FORCE_MIN_LEN);
      rec.position  = pos_ff;
      rec.force_val = frc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         hunting_ff <= 1'b1;
         length_ff  <= '0;
         id_ff      <= '0;
         sum_ff     <= '0;
         pos_ff     <= '0;
         frc_ff     <= '0;
      end else begin
         offset_ff  <= offset_in;
         hunting_ff <= hunting_in;
         length_ff  <= length_in;
         id_ff      <= id_in;
         sum_ff     <= sum_in;
         pos_ff     <= pos_in;
         frc_ff     <= frc_in;
      end
   end

endmodule

>>> rtl/arfp_back.sv
// Back of the parser: looks the frame's id up in the id table, updates the
// per-slot position and force, and forms the result. Uses arfp_pkg.
module arfp_back #(
   parameter int MAX_SLOTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rec_valid,
   input  arfp_pkg::frame_rec_type           rec,
   output logic                              rec_pop,
   input  logic                              res_full,
   output logic                              res_push,
   output arfp_pkg::result_type              res,
   input  logic [arfp_pkg::ID_COUNT_W-1:0]   id_count,
   input  logic [arfp_pkg::ID_TABLE_W-1:0]   id_table
);
   import arfp_pkg::*;

   localparam int SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic signed [15:0] slot_pos_ff [MAX_SLOTS];
   logic signed [15:0] slot_frc_ff [MAX_SLOTS];
   logic               hit;
   logic [SIDX_W-1:0]  hit_idx;
   logic               do_update;

   assign rec_pop  = rec_valid && !res_full;
   assign res_push = rec_pop;

   // Walk from the top slot down so that the lowest matching slot wins.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
         if ((ID_COUNT_W'(k) < id_count) && (id_table[8*k +: 8] == rec.reply_id)) begin
            hit     = 1'b1;
            hit_idx = SIDX_W'(k);
         end
      end
   end

   always_comb begin
      res.status     = ST_OK;
      res.slot_index = '0;
      res.position   = '0;
      res.force_res  = '0;
      do_update      = 1'b0;
      priority if (!rec.sum_ok) begin
         res.status = ST_CSUM;
      end else if (!hit) begin
         res.status = ST_UNKNOWN;
      end else if (rec.is_short) begin
         res.status = ST_SHORT;
      end else begin
         do_update      = rec_pop;
         res.slot_index = SLOT_IDX_W'(hit_idx);
         res.position   = rec.position;
         res.force_res  = rec.has_force ? rec.force_val : slot_frc_ff[hit_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_SLOTS; k++) begin
            slot_pos_ff[k] <= POS_RESET;
            slot_frc_ff[k] <= '0;
         end
      end else if (do_update) begin
         slot_pos_ff[hit_idx] <= rec.position;
         if (rec.has_force) begin
            slot_frc_ff[hit_idx] <= rec.force_val;
         end
      end
   end

endmodule

>>> rtl/actuator_reply_frame_parser_top.sv
// Actuator reply frame parser, top level. Accepts one reply byte per clock and
// stalls (full) only when the two-entry frame queue between the byte front and
// the slot back is full, which happens only after the result queue has filled.
// From its accepted checksum byte, a result is registered in the frame queue
// and then in the result queue. Configuration is taken at any cycle (csr_ready
// is always high). Uses arfp_pkg, arfp_fifo, arfp_front and arfp_back.
module actuator_reply_frame_parser_top #(
   parameter int MAX_SLOTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_start_of_burst,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_slot_index,
   output logic signed [15:0] rsp_position,
   output logic signed [15:0] rsp_force_res,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [63:0]        csr_data
);
   import arfp_pkg::*;

   localparam int REC_W = $bits(frame_rec_type);
   localparam int RES_W = $bits(result_type);
   localparam int QUEUE_DEPTH = 2;

   logic [ID_COUNT_W-1:0] id_count_ff, id_count_in;
   logic [ID_TABLE_W-1:0] id_table_ff, id_table_in;

   logic          accept;
   logic          rec_push, rec_full, rec_empty, rec_pop;
   frame_rec_type rec_new, rec_head;
   logic          res_push, res_full;
   result_type    res_new, res_head;

   assign csr_ready = 1'b1;
   assign full      = rec_full;
   assign accept    = push && !rec_full;

   always_comb begin
      id_count_in = id_count_ff;
      id_table_in = id_table_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ID_COUNT: id_count_in = csr_data[ID_COUNT_W-1:0];
            CSR_ID_TABLE: id_table_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_count_ff <= ID_COUNT_W'(1);
         id_table_ff <= ID_TABLE_W'(1);
      end else begin
         id_count_ff <= id_count_in;
         id_table_ff <= id_table_in;
      end
   end

   arfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_rx_byte),
      .start_of_burst (req_start_of_burst),
      .rec_push       (rec_push),
      .rec            (rec_new)
   );

   arfp_fifo #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_rec_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_new),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_data  (rec_head),
      .empty     (rec_empty)
   );

   arfp_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (!rec_empty),
      .rec       (rec_head),
      .rec_pop   (rec_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_new),
      .id_count  (id_count_ff),
      .id_table  (id_table_ff)
   );

   arfp_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_new),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_head),
      .empty     (empty)
   );

   assign rsp_status     = res_head.status;
   assign rsp_slot_index = res_head.slot_index;
   assign rsp_position   = res_head.position;
   assign rsp_force_res  = res_head.force_res;

   // A closed frame never meets a full frame queue: the front only takes
   // bytes while the queue has room.
   a_rec_room: assert property (@(posedge clock) disable iff (reset)
      rec_push |-> !rec_full) else $error("frame record pushed into full queue");

   a_res_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full) else $error("result pushed into full queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty) else $error("result queue not empty after reset");

   // A failed frame reports neither a slot nor stored values.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != ST_OK) |->
         (rsp_slot_index == '0 && rsp_position == '0 && rsp_force_res == '0))
      else $error("failed frame carries slot data");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for actuator_reply_frame_parser_top: frames and noise
// go in as bytes and each reply is checked against a built-in parser model.
// Depends on arfp_pkg and the RTL of the parser.
module testbench;
   import arfp_pkg::*;

   localparam int SLOT_COUNT    = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 500;
   localparam int PHASE_BYTES   = 50;

   typedef struct packed {
      logic [7:0] rx;
      logic       sob;
   } link_byte_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_start_of_burst = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic [1:0]         rsp_status;
   logic [2:0]         rsp_slot_index;
   logic signed [15:0] rsp_position;
   logic signed [15:0] rsp_force_res;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_ID_COUNT;
   logic [63:0]        csr_data = 64'd0;

   actuator_reply_frame_parser_top #(.MAX_SLOTS(SLOT_COUNT)) dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_rx_byte(req_rx_byte), .req_start_of_burst(req_start_of_burst),
      .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_slot_index(rsp_slot_index),
      .rsp_position(rsp_position), .rsp_force_res(rsp_force_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Parser model state and its copy of the configuration.
   logic [3:0]         cfg_count;
   logic [63:0]        cfg_ids;
   logic [8:0]         at_offset;
   logic               seeking;
   logic [8:0]         frame_end;
   logic [7:0]         model_id;
   logic [7:0]         csum_acc;
   logic [15:0]        pos_acc;
   logic [15:0]        frc_acc;
   logic signed [15:0] slot_pos [SLOT_COUNT];
   logic signed [15:0] slot_frc [SLOT_COUNT];

   result_type    expected_replies [$];
   link_byte_type link_queue [$];

   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   bit  req_done = 1'b0;
   bit  rsp_done = 1'b0;
   bit  steady_flow = 1'b0;
   int  send_gap = 0;
   int  take_gap = 0;
   int  hold_request = 0;
   int  stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap();
      if (steady_flow) return 0;
      return $urandom_range(0, 11);
   endfunction

   // Lowest matching slot among the enabled ones; counts above the table size
   // enable every slot.
   function automatic int find_id_slot(input logic [7:0] id);
      int n;
      n = (cfg_count > SLOT_COUNT) ? SLOT_COUNT : cfg_count;
      for (int k = 0; k < n; k++) begin
         if (cfg_ids[8*k +: 8] == id) return k;
      end
      return -1;
   endfunction

   task automatic reset_parser_model();
      cfg_count = 4'd1;
      cfg_ids   = 64'd1;
      at_offset = 9'd0;
      seeking   = 1'b1;
      frame_end = 9'd0;
      model_id  = 8'd0;
      csum_acc  = 8'd0;
      pos_acc   = 16'd0;
      frc_acc   = 16'd0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         slot_pos[k] = POS_RESET;
         slot_frc[k] = 16'sd0;
      end
   endtask

   // Advances the model by one accepted byte and queues a reply at a checksum byte.
   task automatic parse_rx_byte(input logic [7:0] b, input logic sob);
      result_type r;
      int hit;
      if (sob) begin
         seeking   = 1'b0;
         at_offset = 9'd0;
      end
      if (seeking) return;
      if (at_offset == OFS_HDR0) begin
         if (b != HDR0) begin
            seeking = 1'b1;
            return;
         end
      end else if (at_offset == OFS_HDR1) begin
         if (b != HDR1) begin
            seeking = 1'b1;
            return;
         end
      end else if (at_offset == OFS_LEN) begin
         frame_end = {1'b0, b} + LEN_EXTRA;
         csum_acc  = b;
      end else if (at_offset < frame_end) begin
         csum_acc = csum_acc + b;
         case (at_offset)
            OFS_ID:    model_id = b;
            OFS_POS_L: pos_acc[7:0] = b;
            OFS_POS_H: pos_acc[15:8] = b;
            OFS_FRC_L: frc_acc[7:0] = b;
            OFS_FRC_H: frc_acc[15:8] = b;
            default: ;
         endcase
      end else begin
         seeking = 1'b1;
         hit = find_id_slot(model_id);
         r = '0;
         if (b != csum_acc) r.status = ST_CSUM;
         else if (hit < 0) r.status = ST_UNKNOWN;
         else if (frame_end < SHORT_MIN_LEN) r.status = ST_SHORT;
         else begin
            r.status = ST_OK;
            slot_pos[hit] = pos_acc;
            if (frame_end >= FORCE_MIN_LEN) slot_frc[hit] = frc_acc;
            r.slot_index = 3'(hit);
            r.position   = slot_pos[hit];
            r.force_res  = slot_frc[hit];
         end
         expected_replies = {expected_replies, r};
         return;
      end
      at_offset = at_offset + 9'd1;
   endtask

   task automatic push_byte(input logic [7:0] b, input logic sob);
      link_byte_type item;
      item.rx  = b;
      item.sob = sob;
      link_queue = {link_queue, item};
   endtask

   // Queues one frame; keep > 0 cuts it after that many bytes.
   task automatic queue_frame(input logic [7:0] id, input logic [7:0] len,
                              input logic [15:0] pos, input logic [15:0] frc,
                              input bit bad_sum, input int keep);
      logic [7:0] body [$];
      logic [7:0] sum;
      int last;
      last = len + 4;
      body = {HDR0, HDR1, len, id};
      for (int k = 4; k < last; k++) begin
         case (k)
            9:  body = {body, pos[7:0]};
            10: body = {body, pos[15:8]};
            13: body = {body, frc[7:0]};
            14: body = {body, frc[15:8]};
            default: body = {body, 8'($urandom_range(0, 255))};
         endcase
      end
      sum = 8'd0;
      for (int k = 2; k < last; k++) sum = sum + body[k];
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      body = {body, sum};
      if (keep <= 0 || keep > body.size()) keep = body.size();
      for (int k = 0; k < keep; k++) push_byte(body[k], k == 0);
   endtask

   task automatic queue_random_frame(input bit cut);
      logic [7:0] id;
      logic [7:0] len;
      int pick;
      if ($urandom_range(0, 9) != 0) begin
         pick = $urandom_range(0, SLOT_COUNT - 1);
         id = cfg_ids[8*pick +: 8];
      end else begin
         id = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 8'($urandom_range(0, 6));
      else if (pick < 85) len = 8'($urandom_range(7, 16));
      else if (pick < 98) len = 8'($urandom_range(17, 40));
      else len = 8'($urandom_range(41, 255));
      queue_frame(id, len, 16'($urandom), 16'($urandom), $urandom_range(0, 9) == 0,
                  cut ? $urandom_range(1, len + 4) : 0);
   endtask

   // Line noise and broken headers.
   task automatic queue_junk();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: begin
            repeat ($urandom_range(1, 5))
               push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
         end
         1: begin
            b = 8'($urandom_range(0, 255));
            push_byte((b == HDR0) ? 8'h00 : b, 1'b1);
         end
         2: begin
            b = 8'($urandom_range(0, 255));
            push_byte(HDR0, 1'b1);
            push_byte((b == HDR1) ? 8'h00 : b, 1'b0);
         end
         default: queue_random_frame(1'b1);
      endcase
   endtask

   task automatic fill_random(input int budget);
      int start;
      start = link_queue.size();
      while (link_queue.size() - start < budget) begin
         if ($urandom_range(0, 3) != 0) queue_random_frame(1'b0);
         else queue_junk();
      end
   endtask

   task automatic write_csr(input logic idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ID_COUNT) cfg_count = data[3:0];
      else cfg_ids = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [3:0] count, input logic [63:0] ids);
      logic [63:0] d;
      d = {$urandom, $urandom};
      d[3:0] = count;
      write_csr(CSR_ID_COUNT, d);
      write_csr(CSR_ID_TABLE, ids);
   endtask

   // The sender's queue is empty, nothing is in flight and every reply is in.
   task automatic wait_idle();
      @(posedge clock);
      while (link_queue.size() != 0 || push || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver.
   always @(negedge clock) begin
      link_byte_type item;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_done) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            push <= 1'b0;
         end else if (link_queue.size() != 0) begin
            item = link_queue.pop_front();
            req_rx_byte        <= item.rx;
            req_start_of_burst <= item.sob;
            push               <= 1'b1;
            send_gap = draw_gap();
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Reply receiver, with an occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_request != 0) begin
         stall_left = hold_request;
         hold_request = 0;
         pop <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         pop <= 1'b0;
      end else begin
         if (rsp_done) take_gap = draw_gap();
         if (take_gap != 0) begin
            take_gap = take_gap - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Monitor: checks accepted replies, feeds accepted bytes to the model.
   always @(posedge clock) begin
      result_type want;
      req_done = 1'b0;
      rsp_done = 1'b0;
      if (!reset) begin
         if (pop && !empty) begin
            rsp_done = 1'b1;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected reply: status %0d slot %0d position %0d force %0d",
                        $time, rsp_status, rsp_slot_index, rsp_position, rsp_force_res);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_slot_index !== want.slot_index) begin
                  mismatch_count++;
                  $display("%0t: slot_index expected %0d actual %0d",
                           $time, want.slot_index, rsp_slot_index);
               end
               if (rsp_position !== want.position) begin
                  mismatch_count++;
                  $display("%0t: position expected %0d actual %0d",
                           $time, want.position, rsp_position);
               end
               if (rsp_force_res !== want.force_res) begin
                  mismatch_count++;
                  $display("%0t: force_res expected %0d actual %0d",
                           $time, want.force_res, rsp_force_res);
               end
            end
         end
         if (push && !full) begin
            req_done = 1'b1;
            parse_rx_byte(req_rx_byte, req_start_of_burst);
         end
         if (req_done || rsp_done || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] ids;
      reset_parser_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames against the reset table: id 1 in slot 0 only.
      queue_frame(8'd1, 8'd11, 16'h7FFF, 16'h8000, 1'b0, 0);
      queue_frame(8'd1, 8'd7, 16'h8000, 16'h7FFF, 1'b0, 0);
      queue_frame(8'd1, 8'd10, 16'hFFFF, 16'h1234, 1'b0, 0);
      queue_frame(8'd1, 8'd11, 16'h0001, 16'h0002, 1'b1, 0);
      queue_frame(8'd2, 8'd11, 16'h0003, 16'h0004, 1'b0, 0);
      queue_frame(8'd1, 8'd6, 16'h0005, 16'h0006, 1'b0, 0);
      queue_frame(8'd1, 8'd0, 16'h0000, 16'h0000, 1'b0, 0);
      // A bad checksum outranks an unknown id, which outranks a short frame.
      queue_frame(8'd2, 8'd3, 16'h0000, 16'h0000, 1'b1, 0);
      queue_frame(8'd2, 8'd3, 16'h0000, 16'h0000, 1'b0, 0);
      push_byte(8'h00, 1'b1);
      push_byte(HDR0, 1'b1);
      push_byte(8'h54, 1'b0);
      // While hunting, a header without the burst mark is ignored.
      push_byte(HDR0, 1'b0);
      push_byte(HDR1, 1'b0);
      push_byte(8'hFF, 1'b0);
      queue_frame(8'd1, 8'd20, 16'h1111, 16'h2222, 1'b0, 8);
      queue_frame(8'd1, 8'd12, 16'h3333, 16'h4444, 1'b0, 0);
      queue_frame(8'd1, 8'd255, 16'h5555, 16'h6666, 1'b0, 0);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         ids = {$urandom, $urandom};
         steady_flow = phase[0];
         case (phase)
            0: set_config(4'd8, ids);
            1: set_config(4'd0, ids);
            2: set_config(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
            3: set_config(4'd3, 64'd0);
            4: begin
               ids[47:40] = ids[23:16];
               set_config(4'd9, ids);
            end
            5: begin
               // The receiver holds off while good frames without force keep coming.
               steady_flow = 1'b1;
               set_config(4'd8, 64'h8877_6655_4433_2211);
               hold_request = HOLD_CYCLES;
               repeat (20)
                  queue_frame(8'(8'h11 * $urandom_range(1, 8)), 8'd7, 16'($urandom),
                              16'($urandom), 1'b0, 0);
            end
            6: set_config(4'($urandom_range(0, 15)), ids);
            default: set_config(4'd1, ids);
         endcase
         if (phase != 5) fill_random(PHASE_BYTES);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
